>>> rtl/ptn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Phase transform normalizer package
// Shared constants and the control word that travels with each bin.
// ----------------------------------------------------------------------------
package ptn_pkg;

    // Width of every sample field on the stream ports.
    localparam int DATA_W = 32;

    typedef struct packed {
        logic valid;
        logic zero;
        logic neg_re;
        logic neg_im;
    } ctl_t;

endpackage
`default_nettype wire

>>> rtl/ptn_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Phase transform normalizer front end
// Forms the cross product, its magnitudes and their squares, and the power.
// ----------------------------------------------------------------------------
module ptn_front #(
    parameter int W = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [W-1:0]        ref_re,
    input  wire logic [W-1:0]        ref_im,
    input  wire logic [W-1:0]        test_re,
    input  wire logic [W-1:0]        test_im,
    output ptn_pkg::ctl_t            ctl_o,
    output logic      [4*W-1:0]      num_re_o,
    output logic      [4*W-1:0]      num_im_o,
    output logic      [4*W-1:0]      den_o
);

    localparam int PW = 2 * W;
    localparam int SW = 4 * W;

    logic [2:0]             vld_reg;
    logic signed [W-1:0]    a_reg, b_reg, c_reg, d_reg;
    logic signed [PW-1:0]   ca_reg, db_reg, da_reg, cb_reg;
    logic [PW:0]            sre_reg, sim_reg;
    logic [PW-1:0]          mre_reg, mim_reg;
    logic [PW-1:0]          re_ll_reg, re_lh_reg, re_hh_reg;
    logic [PW-1:0]          im_ll_reg, im_lh_reg, im_hh_reg;
    logic [SW-1:0]          sq_re_reg, sq_im_reg;
    logic [SW-1:0]          den_reg, num_re_reg, num_im_reg;
    ptn_pkg::ctl_t          ctl4_reg, ctl5_reg, ctl6_reg, ctl7_reg;

    logic signed [PW-1:0]   ca_next, db_next, da_next, cb_next;
    logic [PW:0]            sre_next, sim_next;
    logic [PW-1:0]          mre_next, mim_next;
    ptn_pkg::ctl_t          ctl4_next;

    always_comb begin
        ca_next  = c_reg * a_reg;
        db_next  = d_reg * b_reg;
        da_next  = d_reg * a_reg;
        cb_next  = c_reg * b_reg;
        sre_next = {ca_reg[PW-1], ca_reg} + {db_reg[PW-1], db_reg};
        sim_next = {da_reg[PW-1], da_reg} - {cb_reg[PW-1], cb_reg};
        // The magnitude never exceeds 2^(PW-1), so it fits PW unsigned bits.
        mre_next = sre_reg[PW] ? PW'(~sre_reg + 1'b1) : sre_reg[PW-1:0];
        mim_next = sim_reg[PW] ? PW'(~sim_reg + 1'b1) : sim_reg[PW-1:0];
        ctl4_next.valid  = vld_reg[2];
        ctl4_next.zero   = (sre_reg == '0) && (sim_reg == '0);
        ctl4_next.neg_re = sre_reg[PW];
        ctl4_next.neg_im = sim_reg[PW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
            ctl6_reg <= '0;
            ctl7_reg <= '0;
        end else if (en) begin
            vld_reg  <= {vld_reg[1:0], in_valid};
            ctl4_reg <= ctl4_next;
            ctl5_reg <= ctl4_reg;
            ctl6_reg <= ctl5_reg;
            ctl7_reg <= ctl6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg      <= $signed(ref_re);
            b_reg      <= $signed(ref_im);
            c_reg      <= $signed(test_re);
            d_reg      <= $signed(test_im);
            ca_reg     <= ca_next;
            db_reg     <= db_next;
            da_reg     <= da_next;
            cb_reg     <= cb_next;
            sre_reg    <= sre_next;
            sim_reg    <= sim_next;
            mre_reg    <= mre_next;
            mim_reg    <= mim_next;
            // Squares split into half-width partial products.
            re_ll_reg  <= mre_reg[W-1:0] * mre_reg[W-1:0];
            re_lh_reg  <= mre_reg[W-1:0] * mre_reg[PW-1:W];
            re_hh_reg  <= mre_reg[PW-1:W] * mre_reg[PW-1:W];
            im_ll_reg  <= mim_reg[W-1:0] * mim_reg[W-1:0];
            im_lh_reg  <= mim_reg[W-1:0] * mim_reg[PW-1:W];
            im_hh_reg  <= mim_reg[PW-1:W] * mim_reg[PW-1:W];
            sq_re_reg  <= {re_hh_reg, re_ll_reg}
                          + {{(W-1){1'b0}}, re_lh_reg, {(W+1){1'b0}}};
            sq_im_reg  <= {im_hh_reg, im_ll_reg}
                          + {{(W-1){1'b0}}, im_lh_reg, {(W+1){1'b0}}};
            den_reg    <= sq_re_reg + sq_im_reg;
            num_re_reg <= sq_re_reg;
            num_im_reg <= sq_im_reg;
        end
    end

    assign ctl_o    = ctl7_reg;
    assign num_re_o = num_re_reg;
    assign num_im_o = num_im_reg;
    assign den_o    = den_reg;

endmodule
`default_nettype wire

>>> rtl/ptn_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Phase transform normalizer divider cell
// One restoring quotient bit of square over power, for both parts.
// ----------------------------------------------------------------------------
module ptn_div_cell #(
    parameter int W     = 32,
    parameter bit FIRST = 1'b0
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire ptn_pkg::ctl_t       ctl_i,
    input  wire logic [4*W-1:0]      den_i,
    input  wire logic [4*W-1:0]      rem_re_i,
    input  wire logic [4*W-1:0]      rem_im_i,
    input  wire logic [2*W-2:0]      q_re_i,
    input  wire logic [2*W-2:0]      q_im_i,
    output ptn_pkg::ctl_t            ctl_o,
    output logic      [4*W-1:0]      den_o,
    output logic      [4*W-1:0]      rem_re_o,
    output logic      [4*W-1:0]      rem_im_o,
    output logic      [2*W-2:0]      q_re_o,
    output logic      [2*W-2:0]      q_im_o
);

    localparam int SW = 4 * W;
    localparam int QW = 2 * W - 1;

    ptn_pkg::ctl_t   ctl_reg;
    logic [SW-1:0]   den_reg, rem_re_reg, rem_im_reg;
    logic [QW-1:0]   q_re_reg, q_im_reg;
    logic [SW:0]     re_next, im_next;

    // Returns the quotient bit on top of the new partial remainder.
    // The first cell takes the integer bit, so it does not shift.
    function automatic logic [SW:0] div_step(input logic [SW-1:0] rem,
                                             input logic [SW-1:0] den);
        logic [SW:0] sh;
        logic [SW:0] diff;
        logic        ge;
        sh   = FIRST ? {1'b0, rem} : {rem, 1'b0};
        diff = sh - {1'b0, den};
        ge   = (sh >= {1'b0, den});
        return {ge, ge ? diff[SW-1:0] : sh[SW-1:0]};
    endfunction

    always_comb begin
        re_next = div_step(rem_re_i, den_i);
        im_next = div_step(rem_im_i, den_i);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg    <= den_i;
            rem_re_reg <= re_next[SW-1:0];
            rem_im_reg <= im_next[SW-1:0];
            q_re_reg   <= {q_re_i[QW-2:0], re_next[SW]};
            q_im_reg   <= {q_im_i[QW-2:0], im_next[SW]};
        end
    end

    assign ctl_o    = ctl_reg;
    assign den_o    = den_reg;
    assign rem_re_o = rem_re_reg;
    assign rem_im_o = rem_im_reg;
    assign q_re_o   = q_re_reg;
    assign q_im_o   = q_im_reg;

endmodule
`default_nettype wire

>>> rtl/ptn_sqrt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Phase transform normalizer square root cell
// One restoring root bit of the quotient, for both parts.
// ----------------------------------------------------------------------------
module ptn_sqrt_cell #(
    parameter int W = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire ptn_pkg::ctl_t       ctl_i,
    input  wire logic [2*W-1:0]      rad_re_i,
    input  wire logic [2*W-1:0]      rad_im_i,
    input  wire logic [W+1:0]        rem_re_i,
    input  wire logic [W+1:0]        rem_im_i,
    input  wire logic [W-1:0]        root_re_i,
    input  wire logic [W-1:0]        root_im_i,
    output ptn_pkg::ctl_t            ctl_o,
    output logic      [2*W-1:0]      rad_re_o,
    output logic      [2*W-1:0]      rad_im_o,
    output logic      [W+1:0]        rem_re_o,
    output logic      [W+1:0]        rem_im_o,
    output logic      [W-1:0]        root_re_o,
    output logic      [W-1:0]        root_im_o
);

    localparam int RW = 2 * W;

    ptn_pkg::ctl_t   ctl_reg;
    logic [RW-1:0]   rad_re_reg, rad_im_reg;
    logic [W+1:0]    rem_re_reg, rem_im_reg;
    logic [W-1:0]    root_re_reg, root_im_reg;
    logic [W+2:0]    re_next, im_next;

    // Returns the root bit on top of the new remainder. Before a step the
    // remainder stays below 2^W, so its low W bits carry it.
    function automatic logic [W+2:0] sq_step(input logic [W+1:0] rem,
                                             input logic [RW-1:0] rad,
                                             input logic [W-1:0]  root);
        logic [W+1:0] sh;
        logic [W+1:0] trial;
        logic         ge;
        sh    = {rem[W-1:0], rad[RW-1:RW-2]};
        trial = {root, 2'b01};
        ge    = (sh >= trial);
        return {ge, ge ? (sh - trial) : sh};
    endfunction

    always_comb begin
        re_next = sq_step(rem_re_i, rad_re_i, root_re_i);
        im_next = sq_step(rem_im_i, rad_im_i, root_im_i);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_re_reg  <= {rad_re_i[RW-3:0], 2'b00};
            rad_im_reg  <= {rad_im_i[RW-3:0], 2'b00};
            rem_re_reg  <= re_next[W+1:0];
            rem_im_reg  <= im_next[W+1:0];
            root_re_reg <= {root_re_i[W-2:0], re_next[W+2]};
            root_im_reg <= {root_im_i[W-2:0], im_next[W+2]};
        end
    end

    assign ctl_o     = ctl_reg;
    assign rad_re_o  = rad_re_reg;
    assign rad_im_o  = rad_im_reg;
    assign rem_re_o  = rem_re_reg;
    assign rem_im_o  = rem_im_reg;
    assign root_re_o = root_re_reg;
    assign root_im_o = root_im_reg;

endmodule
`default_nettype wire

>>> rtl/phase_transform_normalizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Phase transform normalizer
// Weights one cross-spectrum bin to unit magnitude (PHAT weighting).
// ----------------------------------------------------------------------------
// Each transfer on the s_ channel carries one reference bin and one test bin.
// The block forms test * conj(ref) exactly and returns its real and imaginary
// parts divided by the exact magnitude, truncated toward zero, as Q1.31 on
// the m_ channel. A result of +1.0 saturates to the largest positive code.
// A zero product returns zero with m_tuser set.
// One bin is taken every clock while s_tready is high. The pipeline holds
// seven front-end stages, then a row of 2*SAMPLE_WIDTH-1 divider cells that
// each settle one quotient bit, then a row of SAMPLE_WIDTH root cells that
// each settle one root bit, and the output register. Every cell passes its
// word to the next one on each enabled clock. Reset empties the pipeline
// and both output slots. When the receiver stalls, the output register
// holds its result and one more result lands in a skid register; only then
// is s_tready dropped and the whole row frozen.
// ----------------------------------------------------------------------------
module phase_transform_normalizer #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // ref_re [31:0], ref_im [63:32], test_re [95:64], test_im [127:96]
    input  wire logic [127:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // norm_re [31:0], norm_im [63:32]
    output logic [63:0]        m_tdata,
    // zero_magnitude [0]
    output logic [0:0]         m_tuser
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int DW = ptn_pkg::DATA_W;
    localparam int SW = 4 * W;
    localparam int RW = 2 * W;
    localparam int QW = 2 * W - 1;
    localparam int ND = QW;
    localparam int NS = W;

    logic en;

    ptn_pkg::ctl_t dctl [0:ND];
    logic [SW-1:0] dden [0:ND];
    logic [SW-1:0] drre [0:ND];
    logic [SW-1:0] drim [0:ND];
    logic [QW-1:0] dqre [0:ND];
    logic [QW-1:0] dqim [0:ND];

    ptn_pkg::ctl_t sctl   [0:NS];
    logic [RW-1:0] srad_re [0:NS];
    logic [RW-1:0] srad_im [0:NS];
    logic [W+1:0]  srem_re [0:NS];
    logic [W+1:0]  srem_im [0:NS];
    logic [W-1:0]  sroot_re[0:NS];
    logic [W-1:0]  sroot_im[0:NS];

    logic          m_valid_reg, skid_valid_reg;
    logic [63:0]   m_data_reg, skid_data_reg;
    logic          m_user_reg, skid_user_reg;
    logic [63:0]   fin_data;
    logic          fin_zero;
    logic          fin_valid;

    // The row advances unless both output slots are occupied.
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    ptn_front #(.W(W)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .ref_re   (s_tdata[W-1:0]),
        .ref_im   (s_tdata[DW+W-1:DW]),
        .test_re  (s_tdata[2*DW+W-1:2*DW]),
        .test_im  (s_tdata[3*DW+W-1:3*DW]),
        .ctl_o    (dctl[0]),
        .num_re_o (drre[0]),
        .num_im_o (drim[0]),
        .den_o    (dden[0])
    );

    assign dqre[0] = '0;
    assign dqim[0] = '0;

    for (genvar gi = 0; gi < ND; gi++) begin : g_div
        ptn_div_cell #(.W(W), .FIRST(gi == 0)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .ctl_i    (dctl[gi]),
            .den_i    (dden[gi]),
            .rem_re_i (drre[gi]),
            .rem_im_i (drim[gi]),
            .q_re_i   (dqre[gi]),
            .q_im_i   (dqim[gi]),
            .ctl_o    (dctl[gi+1]),
            .den_o    (dden[gi+1]),
            .rem_re_o (drre[gi+1]),
            .rem_im_o (drim[gi+1]),
            .q_re_o   (dqre[gi+1]),
            .q_im_o   (dqim[gi+1])
        );
    end

    assign sctl[0]     = dctl[ND];
    assign srad_re[0]  = {1'b0, dqre[ND]};
    assign srad_im[0]  = {1'b0, dqim[ND]};
    assign srem_re[0]  = '0;
    assign srem_im[0]  = '0;
    assign sroot_re[0] = '0;
    assign sroot_im[0] = '0;

    for (genvar gj = 0; gj < NS; gj++) begin : g_sqrt
        ptn_sqrt_cell #(.W(W)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .ctl_i     (sctl[gj]),
            .rad_re_i  (srad_re[gj]),
            .rad_im_i  (srad_im[gj]),
            .rem_re_i  (srem_re[gj]),
            .rem_im_i  (srem_im[gj]),
            .root_re_i (sroot_re[gj]),
            .root_im_i (sroot_im[gj]),
            .ctl_o     (sctl[gj+1]),
            .rad_re_o  (srad_re[gj+1]),
            .rad_im_o  (srad_im[gj+1]),
            .rem_re_o  (srem_re[gj+1]),
            .rem_im_o  (srem_im[gj+1]),
            .root_re_o (sroot_re[gj+1]),
            .root_im_o (sroot_im[gj+1])
        );
    end

    // Forces zero for a zero product, applies the sign, saturates +1.0 and sign-extends to the port width.
    function automatic logic [DW-1:0] fmt(input logic [W-1:0] q,
                                          input logic neg,
                                          input logic zero);
        logic [W-1:0] v;
        if (zero) begin
            v = '0;
        end else if (neg) begin
            v = '0 - q;
        end else if (q[W-1]) begin
            v = {1'b0, {(W-1){1'b1}}};
        end else begin
            v = q;
        end
        return DW'($signed(v));
    endfunction

    always_comb begin
        fin_valid = sctl[NS].valid;
        fin_zero  = sctl[NS].zero;
        fin_data  = {fmt(sroot_im[NS], sctl[NS].neg_im, sctl[NS].zero),
                     fmt(sroot_re[NS], sctl[NS].neg_re, sctl[NS].zero)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!m_valid_reg || m_tready) begin
            m_valid_reg <= fin_valid;
        end else if (fin_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                m_data_reg <= skid_data_reg;
                m_user_reg <= skid_user_reg;
            end
        end else if (!m_valid_reg || m_tready) begin
            m_data_reg <= fin_data;
            m_user_reg <= fin_zero;
        end else begin
            skid_data_reg <= fin_data;
            skid_user_reg <= fin_zero;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    a_skid_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register full while output register is empty");

    a_skid_fills_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_tready))
        else $error("skid register filled without a stalled output");

    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("zero-magnitude result carries nonzero data");

endmodule
`default_nettype wire

>>> sim/tb_phase_transform_normalizer.sv
// ----------------------------------------------------------------------------
// Phase transform normalizer testbench
// Streams reference and test bins through the normalizer with random bursts,
// gaps and output stalls. Each accepted bin is run through an exact
// wide-integer model of P/|P|, and every result transfer is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_phase_transform_normalizer;

    localparam int NUM_RANDOM = 1725;
    localparam int DRAIN_AT   = 700;
    localparam int HOLD_AT    = 300;

    typedef struct {
        logic signed [31:0] ref_re, ref_im, test_re, test_im;
    } bin_t;

    typedef struct {
        logic [31:0] norm_re, norm_im;
        logic        zero_mag;
    } unit_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;

    bin_t  pending_bins[$];
    unit_t expected_units[$];
    int    sent_count = 0;
    int    accepted_count = 0;
    int    error_count = 0;
    logic  in_taken = 1'b0;
    logic  stim_done = 1'b0;

    phase_transform_normalizer u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Largest q with q^2 * s <= (mag * 2^31)^2, signed and saturated.
    function automatic logic [31:0] unit_part(logic [63:0] mag, logic neg,
                                              logic [255:0] sumsq);
        logic [255:0] lim;
        logic [255:0] prod;
        logic [32:0]  q;
        logic [32:0]  cand;
        lim = 256'(mag) << 31;
        lim = lim * lim;
        q = '0;
        for (int bitpos = 31; bitpos >= 0; bitpos--) begin
            cand = q | (33'd1 << bitpos);
            prod = 256'(cand) * 256'(cand) * sumsq;
            if (prod <= lim) q = cand;
        end
        if (neg) return 32'(-q);
        if (q > 33'h7fff_ffff) q = 33'h7fff_ffff;
        return q[31:0];
    endfunction

    function automatic unit_t phat_weight(bin_t b);
        unit_t r;
        longint ac, bd, da, cb;
        logic signed [64:0] p_re, p_im;
        logic [63:0] m_re, m_im;
        logic [255:0] sumsq;
        ac = longint'(b.test_re) * longint'(b.ref_re);
        bd = longint'(b.test_im) * longint'(b.ref_im);
        da = longint'(b.test_im) * longint'(b.ref_re);
        cb = longint'(b.test_re) * longint'(b.ref_im);
        p_re = ac;
        p_re = p_re + bd;
        p_im = da;
        p_im = p_im - cb;
        m_re = 64'(p_re < 0 ? -p_re : p_re);
        m_im = 64'(p_im < 0 ? -p_im : p_im);
        if (m_re == 0 && m_im == 0) begin
            r.norm_re = '0;
            r.norm_im = '0;
            r.zero_mag = 1'b1;
            return r;
        end
        sumsq = 256'(m_re) * 256'(m_re) + 256'(m_im) * 256'(m_im);
        r.norm_re = unit_part(m_re, p_re < 0, sumsq);
        r.norm_im = unit_part(m_im, p_im < 0, sumsq);
        r.zero_mag = 1'b0;
        return r;
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 8)) - 4);
            3: return '0;
            4: return 32'($urandom) >>> $urandom_range(0, 31);
            default: return 32'($urandom);
        endcase
    endfunction

    task automatic add_bin(logic [31:0] rr, logic [31:0] ri, logic [31:0] tr,
                           logic [31:0] ti);
        bin_t b;
        b.ref_re = rr;
        b.ref_im = ri;
        b.test_re = tr;
        b.test_im = ti;
        pending_bins.push_back(b);
    endtask

    initial begin
        logic [31:0] mn, mx;
        mn = 32'h8000_0000;
        mx = 32'h7fff_ffff;
        // Zero products from zero inputs on either side.
        add_bin(0, 0, 0, 0);
        add_bin(0, 0, mx, mn);
        add_bin(mn, 5, 0, 0);
        // Pure real product of +1.0 saturates; -1.0 stays representable.
        add_bin(1, 0, 1, 0);
        add_bin(1, 0, -1, 0);
        add_bin(0, 1, 0, 1);
        add_bin(0, mn, 0, mn);
        // Pure imaginary products of both signs.
        add_bin(1, 0, 0, 1);
        add_bin(1, 0, 0, -1);
        add_bin(0, 1, 1, 0);
        // Field extremes; the largest sums reach 2^63.
        add_bin(mn, mn, mn, mn);
        add_bin(mn, mn, mn, mx);
        add_bin(mx, mx, mx, mx);
        add_bin(mx, mn, mn, mx);
        add_bin(mn, mx, mx, mn);
        add_bin(mx, mx, mn, mn);
        // Diagonal and near-diagonal phases exercise truncation.
        add_bin(1, 1, 1, 0);
        add_bin(3, 4, 1, 0);
        add_bin(mx, 1, 1, mx);
        add_bin(-7, 3, 2, -9);
        add_bin(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
        for (int i = 0; i < NUM_RANDOM; i++)
            add_bin(rand_sample(), rand_sample(), rand_sample(), rand_sample());
        stim_done = 1'b1;
    end

    // Sender: bursts of random length separated by random gaps, plus one
    // pause until every outstanding result has come back.
    int burst_left = 0;
    int gap_left = 0;
    logic drain_wait = 1'b0;

    always @(negedge aclk) begin
        bin_t b;
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (sent_count == DRAIN_AT && !drain_wait && expected_units.size() != 0) begin
                drain_wait <= 1'b1;
                s_tvalid <= 1'b0;
            end else if (drain_wait) begin
                s_tvalid <= 1'b0;
                if (expected_units.size() == 0 && !m_tvalid) drain_wait <= 1'b0;
            end else if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_bins.size() != 0) begin
                b = pending_bins.pop_front();
                s_tdata <= {b.test_im, b.test_re, b.ref_im, b.ref_re};
                s_tvalid <= 1'b1;
                sent_count <= sent_count + 1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: the stall pattern is redrawn at random from four modes, with one long hold.
    int rx_cycle = 0;
    int rx_mode = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    always @(negedge aclk) begin
        if (aresetn) begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
            if (!hold_done && accepted_count >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= 400;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 9) < 7);
                    2: m_tready <= rx_cycle[0];
                    default: m_tready <= ($urandom_range(0, 9) < 2);
                endcase
            end
        end
    end

    // Monitor: predict on input transfers, check on output transfers.
    always @(posedge aclk) begin
        bin_t  b;
        unit_t exp_u;
        in_taken <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            b.ref_re = s_tdata[31:0];
            b.ref_im = s_tdata[63:32];
            b.test_re = s_tdata[95:64];
            b.test_im = s_tdata[127:96];
            expected_units.push_back(phat_weight(b));
            accepted_count <= accepted_count + 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_units.size() == 0) begin
                $display("%0t: unexpected result re=%h im=%h zero=%b", $realtime,
                         m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
                error_count <= error_count + 1;
            end else begin
                exp_u = expected_units.pop_front();
                if (m_tdata[31:0] !== exp_u.norm_re || m_tdata[63:32] !== exp_u.norm_im
                        || m_tuser[0] !== exp_u.zero_mag) begin
                    $display("%0t: mismatch expected re=%h im=%h zero=%b, actual re=%h im=%h zero=%b",
                             $realtime, exp_u.norm_re, exp_u.norm_im, exp_u.zero_mag,
                             m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        wait (stim_done && pending_bins.size() == 0 && !s_tvalid);
        wait (expected_units.size() == 0);
        repeat (150) @(posedge aclk);
        if (error_count == 0 && expected_units.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #3000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> files.f
rtl/ptn_pkg.sv
rtl/ptn_front.sv
rtl/ptn_div_cell.sv
rtl/ptn_sqrt_cell.sv
rtl/phase_transform_normalizer.sv
sim/tb_phase_transform_normalizer.sv
